FILE: rtl/savitzky_golay_frame_smoother_unit_defines.svh
// Assertion macros for the frame smoother RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef SAVITZKY_GOLAY_FRAME_SMOOTHER_UNIT_DEFINES_SVH
`define SAVITZKY_GOLAY_FRAME_SMOOTHER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define SGFS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SGFS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SGFS_ASSERT_NOW(label, ante, cons, msg)
`define SGFS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/sgfs_pkg.sv
// Shared types and constants of the frame smoother.
// No dependencies.
package sgfs_pkg;
	localparam int SAMPLE_W       = 16;
	localparam int ACC_W          = 40;
	localparam int PROD_W         = 2 * SAMPLE_W;
	localparam int QUO_W          = ACC_W + 1;
	localparam int POS_W          = 10;
	localparam int CFG_W          = 4;
	localparam int MAX_HALF       = 12;
	localparam int COEF_SLOTS     = MAX_HALF + 2;
	localparam int COEF_AW        = 4;
	localparam int TAP_W          = 5;
	localparam int MIN_FRAME      = 5;
	localparam int MIN_HALF       = 2;
	localparam int MAX_POINTS_DEF = 1024;

	typedef enum logic [1:0] {
		CMD_COEF = 2'd0,
		CMD_PUSH = 2'd1,
		CMD_READ = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef enum logic {
		REG_HALF_WINDOW = 1'b0,
		REG_PASS_COUNT  = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_INIT,
		ST_ISSUE,
		ST_DRAIN,
		ST_DIV,
		ST_DIV_WAIT,
		ST_WRITE
	} seq_state_t;

	typedef struct packed {
		logic                       start;
		logic signed [ACC_W-1:0]    acc;
		logic signed [SAMPLE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                       done;
		logic signed [SAMPLE_W-1:0] result;
	} div_rsp_t;
endpackage

FILE: rtl/sgfs_frame_mem.sv
// Frame sample store: one write and one registered read per cycle.
// Depends on sgfs_pkg.
module sgfs_frame_mem #(
	parameter int DEPTH = sgfs_pkg::MAX_POINTS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [AW-1:0]                      waddr,
	input  logic signed [sgfs_pkg::SAMPLE_W-1:0] wdata,
	input  logic [AW-1:0]                      raddr,
	output logic signed [sgfs_pkg::SAMPLE_W-1:0] rdata
);
	import sgfs_pkg::*;

	logic signed [SAMPLE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/sgfs_div.sv
// Rounded signed divide of the 40-bit sum by the table divisor, one bit a cycle,
// saturated to the sample width. Depends on sgfs_pkg.
module sgfs_div (
	input  logic               clk,
	input  logic               arst_n,
	input  sgfs_pkg::div_req_t req,
	output sgfs_pkg::div_rsp_t rsp
);
	import sgfs_pkg::*;

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic                run_q;
	logic                fin_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [QUO_W-1:0]    quo_q;
	logic [SAMPLE_W-1:0] rem_q;
	logic [SAMPLE_W-1:0] md_q;
	logic                neg_q;
	logic                done_q;
	logic signed [SAMPLE_W-1:0] res_q;

	logic [ACC_W-1:0]    ma;
	logic [SAMPLE_W-1:0] md;
	logic [QUO_W-1:0]    dvd;
	logic [SAMPLE_W:0]   trial;
	logic                fits;
	logic [SAMPLE_W-1:0] sat;

	always_comb begin
		ma    = req.acc[ACC_W-1] ? ACC_W'(-req.acc) : ACC_W'(req.acc);
		md    = req.divisor[SAMPLE_W-1] ? SAMPLE_W'(-req.divisor) : SAMPLE_W'(req.divisor);
		dvd   = {1'b0, ma} + QUO_W'(md >> 1);
		trial = {rem_q, quo_q[QUO_W-1]};
		fits  = trial >= {1'b0, md_q};
		// quotient limits: +max for positive, -min magnitude for negative
		if (!neg_q) begin
			sat = (quo_q > QUO_W'((1 << (SAMPLE_W - 1)) - 1)) ?
				SAMPLE_W'((1 << (SAMPLE_W - 1)) - 1) : quo_q[SAMPLE_W-1:0];
		end else begin
			sat = (quo_q > QUO_W'(1 << (SAMPLE_W - 1))) ?
				SAMPLE_W'(1 << (SAMPLE_W - 1)) : SAMPLE_W'(-quo_q[SAMPLE_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(QUO_W - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
			if (fin_q) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= dvd;
			rem_q <= '0;
			md_q  <= md;
			neg_q <= req.acc[ACC_W-1] != req.divisor[SAMPLE_W-1];
		end else if (run_q) begin
			rem_q <= fits ? SAMPLE_W'(trial - {1'b0, md_q}) : trial[SAMPLE_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
		if (fin_q) begin
			res_q <= sat;
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;
endmodule

FILE: rtl/sgfs_ctrl.sv
// Smoothing sequencer: coefficient table, left-neighbor ring, tap MAC pipeline.
// Depends on sgfs_pkg and the assertion macro header.
`include "savitzky_golay_frame_smoother_unit_defines.svh"
module sgfs_ctrl #(
	parameter int MAX_POINTS = sgfs_pkg::MAX_POINTS_DEF,
	parameter int AW         = $clog2(MAX_POINTS),
	parameter int LW         = AW + 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 go,
	input  logic [LW-1:0]                        frame_len,
	input  logic [sgfs_pkg::CFG_W-1:0]           half_window,
	input  logic [sgfs_pkg::CFG_W-1:0]           pass_count,
	input  logic                                 coef_we,
	input  logic [sgfs_pkg::COEF_AW-1:0]         coef_idx,
	input  logic signed [sgfs_pkg::SAMPLE_W-1:0] coef_data,
	output logic [AW-1:0]                        mem_raddr,
	input  logic signed [sgfs_pkg::SAMPLE_W-1:0] mem_rdata,
	output logic                                 mem_we,
	output logic [AW-1:0]                        mem_waddr,
	output logic signed [sgfs_pkg::SAMPLE_W-1:0] mem_wdata,
	output logic                                 busy,
	output sgfs_pkg::div_req_t                   div_req,
	input  sgfs_pkg::div_rsp_t                   div_rsp
);
	import sgfs_pkg::*;

	seq_state_t state_q, state_d;

	logic signed [SAMPLE_W-1:0] coef_q [COEF_SLOTS];
	logic signed [SAMPLE_W-1:0] ring_q [MAX_HALF];

	logic [CFG_W-1:0] h;
	logic [CFG_W-1:0] passes;
	logic [CFG_W-1:0] k_q;
	logic [CFG_W-1:0] pass_q;
	logic [AW-1:0]    i_q;
	logic [TAP_W-1:0] t_q;
	logic [TAP_W-1:0] two_h;
	logic             skip;
	logic             last_pt;
	logic             last_pass;

	logic                       v_s1, init_s1;
	logic [TAP_W-1:0]           t_s1;
	logic                       v_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SAMPLE_W-1:0] cur_q;

	logic signed [SAMPLE_W-1:0] tap_sample;
	logic [COEF_AW-1:0]         tap_coef;
	logic [TAP_W-1:0]           tap_dist;
	logic [CFG_W-1:0]           ring_idx;
	logic signed [SAMPLE_W-1:0] divisor;

	always_comb begin
		h         = (half_window > CFG_W'(MAX_HALF)) ? CFG_W'(MAX_HALF) : half_window;
		passes    = (pass_count == '0) ? CFG_W'(1) : pass_count;
		two_h     = {h, 1'b0};
		skip      = (frame_len < LW'(MIN_FRAME)) || (h < CFG_W'(MIN_HALF)) ||
			(frame_len <= LW'(two_h));
		last_pt   = ({1'b0, i_q} + LW'(1)) == (frame_len - LW'(h));
		last_pass = (pass_q + CFG_W'(1)) == passes;
		divisor   = coef_q[0];
		tap_dist  = (t_s1 >= TAP_W'(h)) ? (t_s1 - TAP_W'(h)) : (TAP_W'(h) - t_s1);
		tap_coef  = COEF_AW'(tap_dist + TAP_W'(1));
		ring_idx  = CFG_W'(TAP_W'(h) - t_s1 - TAP_W'(1));
		// first pass takes left neighbors from the ring of original samples
		if (pass_q == '0 && t_s1 < TAP_W'(h)) begin
			tap_sample = ring_q[ring_idx];
		end else begin
			tap_sample = mem_rdata;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (go) state_d = ST_CHECK;
			ST_CHECK:    state_d = skip ? ST_IDLE : ST_INIT;
			ST_INIT:     if (k_q == h - CFG_W'(1)) state_d = ST_ISSUE;
			ST_ISSUE:    if (t_q == two_h) state_d = ST_DRAIN;
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = (divisor == '0) ? ST_WRITE : ST_DIV;
				end
			end
			ST_DIV:      state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: if (div_rsp.done) state_d = ST_WRITE;
			ST_WRITE:    state_d = (last_pt && last_pass) ? ST_IDLE : ST_ISSUE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy            = state_q != ST_IDLE;
		mem_raddr       = '0;
		mem_we          = 1'b0;
		mem_waddr       = i_q;
		mem_wdata       = div_rsp.result;
		div_req.start   = 1'b0;
		div_req.acc     = acc_q;
		div_req.divisor = divisor;
		case (state_q)
			ST_INIT:  mem_raddr = AW'(k_q);
			ST_ISSUE: mem_raddr = AW'(({1'b0, i_q} + LW'(t_q)) - LW'(h));
			ST_DIV:   div_req.start = 1'b1;
			ST_WRITE: mem_we = divisor != '0;
			default:  mem_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			v_s1    <= 1'b0;
			init_s1 <= 1'b0;
			v_s2    <= 1'b0;
			for (int n = 0; n < COEF_SLOTS; n++) begin
				coef_q[n] <= '0;
			end
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == ST_ISSUE) || (state_q == ST_INIT);
			init_s1 <= state_q == ST_INIT;
			v_s2    <= v_s1 && !init_s1;
			if (coef_we) begin
				coef_q[coef_idx] <= coef_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		t_s1 <= t_q;
		if (v_s1 && !init_s1) begin
			prod_s2 <= tap_sample * coef_q[tap_coef];
			if (t_s1 == TAP_W'(h)) begin
				cur_q <= mem_rdata;
			end
		end
		if ((v_s1 && init_s1) || (state_q == ST_WRITE && pass_q == '0)) begin
			ring_q[0] <= init_s1 ? mem_rdata : cur_q;
			for (int n = 1; n < MAX_HALF; n++) begin
				ring_q[n] <= ring_q[n-1];
			end
		end
		if (v_s2) begin
			acc_q <= acc_q + {{(ACC_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
		case (state_q)
			ST_CHECK: k_q <= '0;
			ST_INIT: begin
				k_q <= k_q + CFG_W'(1);
				if (k_q == h - CFG_W'(1)) begin
					i_q    <= AW'(h);
					t_q    <= '0;
					pass_q <= '0;
					acc_q  <= '0;
				end
			end
			ST_ISSUE: t_q <= t_q + TAP_W'(1);
			ST_WRITE: begin
				t_q   <= '0;
				acc_q <= '0;
				if (last_pt) begin
					i_q    <= AW'(h);
					pass_q <= pass_q + CFG_W'(1);
				end else begin
					i_q <= i_q + AW'(1);
				end
			end
			default: k_q <= k_q;
		endcase
	end

	`SGFS_ASSERT_NOW(a_we_nonzero_div, mem_we, divisor != '0, "store write with zero divisor")
	`SGFS_ASSERT_NEXT(a_div_start, div_req.start, state_q == ST_DIV_WAIT, "divide not awaited")
	`SGFS_ASSERT_NOW(a_div_done, div_rsp.done, state_q == ST_DIV_WAIT, "stray divide result")
	`SGFS_ASSERT_NOW(a_tap_range, state_q == ST_ISSUE, t_q <= two_h, "tap beyond window")
endmodule

FILE: rtl/savitzky_golay_frame_smoother_unit.sv
// Frame smoother top level: host command decode, frame length, read return.
// Depends on sgfs_pkg, sgfs_frame_mem, sgfs_ctrl, sgfs_div.
//
// Commands are taken one per cycle while busy is low. Coefficient writes and
// sample pushes give no result; a read returns its word with strobe out_valid
// in the cycle after it is taken, and the receiver cannot stall it. A push
// with last starts smoothing and raises busy: with W = 2*half_window + 1 taps,
// each interior point makes W reads through the single frame store read port,
// drains the MAC pipeline, then runs the 41-step bit-serial divider and writes
// the point back; with a zero divisor the divide and the write are skipped.
// The burst makes passes runs over all interior points, after a check of the
// frame and a preload of the original-sample ring; a frame too short to smooth
// holds busy for one cycle.
// The store needs no clearing pass.
module savitzky_golay_frame_smoother_unit #(
	parameter int MAX_POINTS = sgfs_pkg::MAX_POINTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           command,
	input  logic [sgfs_pkg::POS_W-1:0]           position,
	input  logic signed [sgfs_pkg::SAMPLE_W-1:0] value,
	input  logic                                 last,
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [sgfs_pkg::CFG_W-1:0]           cfg_data,
	output logic                                 out_valid,
	output logic signed [sgfs_pkg::SAMPLE_W-1:0] sample_out,
	output logic [sgfs_pkg::POS_W-1:0]           read_position
);
	import sgfs_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int LW = AW + 1;
	localparam int CW = (LW > POS_W) ? LW : POS_W;

	logic [CFG_W-1:0] half_q, passes_q;
	logic [LW-1:0]    len_q;
	logic             closed_q;
	logic             rd_s1, inrange_s1;
	logic [POS_W-1:0] pos_s1;

	logic             accept, do_push, do_read, do_coef;
	logic [LW-1:0]    len_base;
	logic             room;
	logic [CW-1:0]    pos_ext;

	logic                       seq_busy;
	logic [AW-1:0]              seq_raddr, seq_waddr;
	logic                       seq_we;
	logic signed [SAMPLE_W-1:0] seq_wdata;
	logic                       mem_we;
	logic [AW-1:0]              mem_waddr, mem_raddr;
	logic signed [SAMPLE_W-1:0] mem_wdata, mem_rdata;
	div_req_t                   div_req;
	div_rsp_t                   div_rsp;

	always_comb begin
		accept   = start && !seq_busy;
		do_push  = accept && (cmd_t'(command) == CMD_PUSH);
		do_read  = accept && (cmd_t'(command) == CMD_READ);
		do_coef  = accept && (cmd_t'(command) == CMD_COEF) &&
			(position < POS_W'(COEF_SLOTS));
		len_base = closed_q ? '0 : len_q;
		room     = len_base < LW'(MAX_POINTS);
		pos_ext  = CW'(position);
		mem_we    = seq_busy ? seq_we : (do_push && room);
		mem_waddr = seq_busy ? seq_waddr : len_base[AW-1:0];
		mem_wdata = seq_busy ? seq_wdata : value;
		mem_raddr = seq_busy ? seq_raddr : pos_ext[AW-1:0];
	end

	assign busy = seq_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q   <= CFG_W'(2);
			passes_q <= CFG_W'(1);
			len_q    <= '0;
			closed_q <= 1'b0;
			rd_s1    <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (reg_idx_t'(cfg_index) == REG_HALF_WINDOW) begin
					half_q <= cfg_data;
				end else begin
					passes_q <= cfg_data;
				end
			end
			if (do_push) begin
				len_q    <= len_base + LW'(room);
				closed_q <= last;
			end
			rd_s1 <= do_read;
		end
	end

	always_ff @(posedge clk) begin
		if (do_read) begin
			pos_s1     <= position;
			inrange_s1 <= pos_ext < CW'(len_q);
		end
	end

	assign out_valid     = rd_s1;
	assign sample_out    = inrange_s1 ? mem_rdata : '0;
	assign read_position = pos_s1;

	sgfs_frame_mem #(
		.DEPTH (MAX_POINTS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	sgfs_ctrl #(
		.MAX_POINTS (MAX_POINTS),
		.AW         (AW),
		.LW         (LW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (do_push && last),
		.frame_len   (len_q),
		.half_window (half_q),
		.pass_count  (passes_q),
		.coef_we     (do_coef),
		.coef_idx    (position[COEF_AW-1:0]),
		.coef_data   (value),
		.mem_raddr   (seq_raddr),
		.mem_rdata   (mem_rdata),
		.mem_we      (seq_we),
		.mem_waddr   (seq_waddr),
		.mem_wdata   (seq_wdata),
		.busy        (seq_busy),
		.div_req     (div_req),
		.div_rsp     (div_rsp)
	);

	sgfs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);
endmodule

FILE: tb/savitzky_golay_frame_smoother_unit_tb.sv
// Testbench for the frame smoother: drives commands and register writes, predicts
// each read word in a scoreboard class and checks it. Needs sgfs_pkg and the RTL.
`timescale 1ns / 1ps

module savitzky_golay_frame_smoother_unit_tb;
	import sgfs_pkg::*;

	class frame_board;
		int unsigned half_reg;
		int unsigned pass_reg;
		int          coef[COEF_SLOTS];
		int          frame[MAX_POINTS_DEF];
		int          orig_ring[MAX_HALF];
		int unsigned frame_len;
		bit          closed;
		logic [SAMPLE_W+POS_W-1:0] read_words[$];
		int          mismatches;

		function new();
			half_reg   = 2;
			pass_reg   = 1;
			frame_len  = 0;
			closed     = 0;
			mismatches = 0;
			foreach (coef[k]) coef[k] = 0;
			foreach (frame[k]) frame[k] = 0;
			foreach (orig_ring[k]) orig_ring[k] = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
			if (idx == REG_HALF_WINDOW) half_reg = 32'(data);
			else pass_reg = 32'(data);
		endfunction

		// 40-bit wrap, divide rounding half away from zero, saturate to 16 bits
		function int round_sat(longint acc, int dv);
			logic signed [ACC_W-1:0] a40;
			longint a, ma, md, q, r;
			a40 = acc[ACC_W-1:0];
			a = longint'(a40);
			ma = (a < 0) ? -a : a;
			md = (dv < 0) ? -longint'(dv) : longint'(dv);
			q = (ma + md / 2) / md;
			r = ((a < 0) != (dv < 0)) ? -q : q;
			if (r > 32767) r = 32767;
			if (r < -32768) r = -32768;
			return int'(r);
		endfunction

		function void smooth_frame();
			int unsigned h, passes, n;
			int          dv, cur, lft;
			longint      acc, c;
			h = (half_reg > MAX_HALF) ? MAX_HALF : half_reg;
			passes = (pass_reg < 1) ? 1 : pass_reg;
			n = frame_len;
			dv = coef[0];
			if (n < MIN_FRAME || h < MIN_HALF || n <= 2 * h) return;
			for (int k = 0; k < h; k++) orig_ring[k % MAX_HALF] = frame[k];
			for (int p = 0; p < passes; p++) begin
				for (int i = h; i < n - h; i++) begin
					acc = longint'(frame[i]) * coef[1];
					cur = frame[i];
					for (int j = 1; j <= h; j++) begin
						lft = (p == 0) ? orig_ring[(i - j) % MAX_HALF] : frame[i - j];
						c = longint'(coef[j + 1]);
						acc += longint'(lft) * c + longint'(frame[i + j]) * c;
					end
					if (p == 0) orig_ring[i % MAX_HALF] = cur;
					if (dv != 0) frame[i] = round_sat(acc, dv);
				end
			end
		endfunction

		function void note_input(cmd_t cmd, logic [POS_W-1:0] pos,
				logic signed [SAMPLE_W-1:0] val, logic lst);
			logic [SAMPLE_W-1:0] s;
			case (cmd)
			CMD_COEF: begin
				if (pos < COEF_SLOTS) coef[pos] = int'(val);
			end
			CMD_PUSH: begin
				if (closed) begin
					frame_len = 0;
					closed = 0;
				end
				if (frame_len < MAX_POINTS_DEF) begin
					frame[frame_len] = int'(val);
					frame_len++;
				end
				if (lst) begin
					smooth_frame();
					closed = 1;
				end
			end
			CMD_READ: begin
				s = (pos < frame_len) ? frame[pos][SAMPLE_W-1:0] : '0;
				read_words.push_back({s, pos});
			end
			default: ;
			endcase
		endfunction

		function void check_result(logic [SAMPLE_W-1:0] s, logic [POS_W-1:0] p);
			logic [SAMPLE_W+POS_W-1:0] want;
			if (read_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: sample_out %0d read_position %0d",
						$signed(s), p);
				return;
			end
			want = read_words.pop_front();
			if (want[SAMPLE_W+POS_W-1:POS_W] !== s || want[POS_W-1:0] !== p) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: sample_out exp %0d got %0d, read_position exp %0d got %0d",
						$signed(want[SAMPLE_W+POS_W-1:POS_W]), $signed(s),
						want[POS_W-1:0], p);
			end
		endfunction
	endclass

	logic                       clk = 0;
	logic                       arst_n = 0;
	logic                       start = 0;
	logic                       busy;
	logic [1:0]                 command = '0;
	logic [POS_W-1:0]           position = '0;
	logic signed [SAMPLE_W-1:0] value = '0;
	logic                       last = 0;
	logic                       cfg_we = 0;
	logic                       cfg_index = 0;
	logic [CFG_W-1:0]           cfg_data = '0;
	logic                       out_valid;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic [POS_W-1:0]           read_position;

	frame_board sb = new();
	int unsigned gap_pct = 6;
	int unsigned item_count = 0;
	longint      cycles = 0;

	savitzky_golay_frame_smoother_unit dut (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid) sb.check_result(sample_out, read_position);

	// returns at the edge that took the word
	task automatic send(cmd_t cmd, int pos, int val, int lst);
		while ($urandom_range(0, 99) < gap_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start    <= 1;
		command  <= cmd;
		position <= POS_W'(pos);
		value    <= SAMPLE_W'(val);
		last     <= lst[0];
		do @(posedge clk); while (busy);
		sb.note_input(cmd, POS_W'(pos), SAMPLE_W'(val), lst[0]);
		item_count++;
	endtask

	task automatic go_quiet();
		start <= 0;
		@(posedge clk);
	endtask

	// only once the block is idle and every read word is back
	task automatic write_reg(reg_idx_t idx, int data);
		go_quiet();
		while (busy || sb.read_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(data);
		@(posedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, CFG_W'(data));
	endtask

	function automatic int rand_tap();
		case ($urandom_range(0, 5))
		0:       return $urandom;
		1:       return 0;
		default: return int'($urandom_range(0, 128)) - 64;
		endcase
	endfunction

	task automatic load_coefs();
		case ($urandom_range(0, 7))
		0:       send(CMD_COEF, 0, 0, $urandom);
		1:       send(CMD_COEF, 0, -int'($urandom_range(1, 300)), $urandom);
		2:       send(CMD_COEF, 0, $urandom, $urandom);
		default: send(CMD_COEF, 0, $urandom_range(1, 400), $urandom);
		endcase
		for (int k = 1; k < COEF_SLOTS; k++)
			if ($urandom_range(0, 2) != 0) send(CMD_COEF, k, rand_tap(), $urandom);
	endtask

	task automatic run_frame(int unsigned len, bit wide);
		int v;
		for (int k = 0; k < len; k++) begin
			v = wide ? int'($urandom) : int'($urandom_range(0, 2000)) - 1000;
			send(CMD_PUSH, $urandom, v, int'(k == len - 1));
			// noise: reads of the partial frame, idle commands, dead coef slots
			case ($urandom_range(0, 19))
			0: send(CMD_READ, $urandom_range(0, k), $urandom, $urandom);
			1: send(CMD_NOP, $urandom, $urandom, $urandom);
			2: send(CMD_COEF, $urandom_range(COEF_SLOTS, 1023), $urandom, $urandom);
			default: ;
			endcase
		end
		repeat ($urandom_range(2, 6)) send(CMD_READ, $urandom_range(0, len - 1), $urandom,
			$urandom);
		if ($urandom_range(0, 2) == 0) send(CMD_READ, $urandom_range(len, 1023), $urandom,
			$urandom);
	endtask

	initial begin
		int unsigned len, hw, np, nframe;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty reads, coef table, short frame, extremes
		send(CMD_READ, 0, 0, 0);
		send(CMD_READ, 1023, -1, 1);
		send(CMD_NOP, 1023, 'h7fff, 1);
		send(CMD_COEF, 14, 'h5555, 0);
		send(CMD_COEF, 1023, 'haaaa, 1);
		send(CMD_COEF, 0, 1, 0);
		send(CMD_COEF, 1, 'h7fff, 0);
		send(CMD_COEF, 2, 'h7fff, 0);
		send(CMD_COEF, 3, -32768, 0);
		for (int k = 4; k < COEF_SLOTS; k++) send(CMD_COEF, k, k, 0);
		for (int k = 0; k < 4; k++) send(CMD_PUSH, 0, 'h7fff, int'(k == 3));
		send(CMD_READ, 2, 0, 0);
		foreach (sb.frame[k])
			if (k < 6) send(CMD_PUSH, 0, (k % 2) ? -32768 : 32767, int'(k == 5));
		for (int k = 0; k < 6; k++) send(CMD_READ, k, 0, 0);
		send(CMD_COEF, 0, 0, 0);
		for (int k = 0; k < 6; k++) send(CMD_PUSH, 0, k * 1000, int'(k == 5));
		send(CMD_READ, 2, 0, 0);

		// full frame: pushes past the store are dropped
		write_reg(REG_HALF_WINDOW, 2);
		write_reg(REG_PASS_COUNT, 0);
		send(CMD_COEF, 0, -3, 0);
		for (int k = 0; k < MAX_POINTS_DEF + 6; k++) send(CMD_PUSH, 0, $urandom,
			int'(k == MAX_POINTS_DEF + 5));
		send(CMD_READ, 1023, 0, 0);
		send(CMD_READ, 512, 0, 0);
		send(CMD_READ, 0, 0, 0);

		item_count = 0;
		nframe = 0;
		while (item_count < 700) begin
			gap_pct = (item_count < 230) ? 6 : (item_count < 470) ? 66 : 0;
			case ($urandom_range(0, 9))
			0:       hw = $urandom_range(0, 1);
			1:       hw = $urandom_range(12, 15);
			default: hw = $urandom_range(2, 6);
			endcase
			np = ($urandom_range(0, 9) == 0) ? 15 : $urandom_range(0, 3);
			if (nframe % 3 == 0) write_reg(REG_HALF_WINDOW, hw);
			if (nframe % 4 == 1) write_reg(REG_PASS_COUNT, np);
			if ($urandom_range(0, 2) == 0 || nframe == 0) load_coefs();
			case ($urandom_range(0, 9))
			0:       len = $urandom_range(1, 4);
			1:       len = $urandom_range(25, 60);
			default: len = $urandom_range(5, 28);
			endcase
			if (sb.pass_reg > 3 && len > 14) len = 14;
			run_frame(len, $urandom_range(0, 1));
			nframe++;
		end

		go_quiet();
		while (sb.read_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
